// ===== rtl/core/sis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types, codes and constants of the seeded index shuffler: item
// structs, controller to datapath command and status groups, generator
// constants.
// ----------------------------------------------------------------------------
package sis_pkg;

	// default table depth
	localparam int DEF_MAX_ENTRIES = 1024;

	// field widths
	localparam int ENTRY_W   = 10;
	localparam int POS_W     = 10;
	localparam int COUNT_W   = 11;
	localparam int SEED_W    = 64;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 1;

	// register reset values
	localparam logic [COUNT_W-1:0] RESET_COUNT = 11'd1024;
	localparam logic [SEED_W-1:0]  RESET_SEED  = 64'd42;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
	localparam int          SHIFT_A      = 30;
	localparam int          SHIFT_B      = 27;
	localparam int          SHIFT_C      = 31;

	// item operation codes
	localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
	localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE  = 1'b1;

	// request and response items
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] position;
	} sis_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry_value;
		logic               out_of_range;
	} sis_rsp_t;

	// multiplier partial product phase
	typedef enum logic [1:0] {
		MUL_LO   = 2'd0,
		MUL_HI_X = 2'd1,
		MUL_HI_K = 2'd2
	} mul_phase_t;

	// table read address select
	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_POS  = 2'd1,
		RD_A    = 2'd2,
		RD_J    = 2'd3
	} rd_sel_t;

	// table write select
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_FILL = 2'd1,
		WR_A    = 2'd2,
		WR_B    = 2'd3
	} wr_sel_t;

	// response contents
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_DATA = 2'd1,
		RES_OOR  = 2'd2
	} res_kind_t;

	// controller to datapath commands
	typedef struct packed {
		logic       take;
		logic       rng_load;
		logic       rng_adv;
		logic       fill_start;
		logic       i_load;
		logic       i_dec;
		logic       mul_en;
		logic       mul_sel_b;
		mul_phase_t mul_phase;
		logic       mix27;
		logic       div_load;
		logic       div_step;
		rd_sel_t    rd_sel;
		logic       tmp_ld;
		wr_sel_t    wr_sel;
		res_kind_t  res_kind;
	} sis_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic fill_last;
		logic i_gt1;
		logic div_last;
		logic in_range;
	} sis_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sis_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sis_dpath
// Datapath: index table memory, splitmix64 generator with a shared 32x32
// multiplier, bit-serial remainder unit and the shuffle counters.
// ----------------------------------------------------------------------------
module sis_dpath import sis_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sis_cmd_t           cmd,
	output sis_sts_t           sts,
	input  logic [POS_W-1:0]   position,
	input  logic [COUNT_W-1:0] entry_count,
	input  logic [SEED_W-1:0]  seed_value,
	output sis_rsp_t           res
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int DIVC_W = $clog2(SEED_W);

	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   act_ext;
	logic [CNT_W-1:0]   act_cnt;
	logic [POS_W-1:0]   pos_q;
	logic [63:0]        rng_q;
	logic [63:0]        rng_next;
	logic [63:0]        x_q;
	logic [63:0]        acc_q;
	logic [63:0]        mul_k;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic [63:0]        dvd_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W:0]     trial;
	logic [CNT_W:0]     i_ext;
	logic [CNT_W-1:0]   rem_nxt;
	logic [DIVC_W-1:0]  div_cnt_q;
	logic [CNT_W-1:0]   i_q;
	logic [IDX_W-1:0]   fill_q;
	logic [IDX_W-1:0]   addr_a;
	logic [IDX_W-1:0]   addr_j;
	logic [IDX_W-1:0]   addr_pos;
	logic               wr_en;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic               rd_en;
	logic [IDX_W-1:0]   raddr;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] tmp_q;
	logic [ENTRY_W-1:0] tbl_mem [MAX_ENTRIES];

	// active count, saturated to the table depth
	assign count_ext = CMP_W'(entry_count);
	assign act_cnt   = (count_ext > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
	                                                      : CNT_W'(count_ext);
	assign act_ext   = CMP_W'(act_cnt);
	assign pos_ext   = CMP_W'(pos_q);

	// read position captured with the item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pos_q <= position;
		end
	end

	// generator state
	assign rng_next = rng_q + GOLDEN_GAMMA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= RESET_SEED;
		end else if (cmd.rng_load) begin
			rng_q <= (seed_value == '0) ? 64'd1 : seed_value;
		end else if (cmd.rng_adv) begin
			rng_q <= rng_next;
		end
	end

	// multiplier operand, first and second mixing rounds
	always_ff @(posedge clk) begin
		if (cmd.rng_adv) begin
			x_q <= rng_next ^ (rng_next >> SHIFT_A);
		end else if (cmd.mix27) begin
			x_q <= acc_q ^ (acc_q >> SHIFT_B);
		end
	end

	// low 64 bits of x times k from three 32x32 partial products
	assign mul_k = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a = (cmd.mul_phase == MUL_HI_X) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (cmd.mul_phase == MUL_HI_K) ? mul_k[63:32] : mul_k[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			if (cmd.mul_phase == MUL_LO) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	// restoring remainder, one dividend bit a cycle
	assign trial   = {rem_q, dvd_q[63]};
	assign i_ext   = {1'b0, i_q};
	assign rem_nxt = (trial >= i_ext) ? CNT_W'(trial - i_ext) : CNT_W'(trial);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= acc_q ^ (acc_q >> SHIFT_C);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	// step counter, walk index and fill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			i_q       <= '0;
			fill_q    <= '0;
		end else begin
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIVC_W'(1);
			end
			if (cmd.i_load) begin
				i_q <= act_cnt;
			end else if (cmd.i_dec) begin
				i_q <= i_q - CNT_W'(1);
			end
			if (cmd.fill_start) begin
				fill_q <= '0;
			end else if (cmd.wr_sel == WR_FILL) begin
				fill_q <= fill_q + IDX_W'(1);
			end
		end
	end

	// table addresses
	assign addr_a   = IDX_W'(i_q - CNT_W'(1));
	assign addr_j   = IDX_W'(rem_q);
	assign addr_pos = IDX_W'(pos_ext);

	// write port select
	always_comb begin
		wr_en = 1'b1;
		waddr = fill_q;
		wdata = rd_q;
		case (cmd.wr_sel)
			WR_FILL: begin
				wdata = ENTRY_W'(fill_q);
			end
			WR_A: begin
				waddr = addr_a;
			end
			WR_B: begin
				waddr = addr_j;
				wdata = tmp_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// read port select
	always_comb begin
		rd_en = 1'b1;
		raddr = addr_pos;
		case (cmd.rd_sel)
			RD_POS: raddr = addr_pos;
			RD_A:   raddr = addr_a;
			RD_J:   raddr = addr_j;
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// index table, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= tbl_mem[raddr];
		end
	end

	// first swap operand
	always_ff @(posedge clk) begin
		if (cmd.tmp_ld) begin
			tmp_q <= rd_q;
		end
	end

	// status back to the controller
	assign sts.fill_last = (fill_q == IDX_W'(MAX_ENTRIES - 1));
	assign sts.i_gt1     = (i_q > CNT_W'(1));
	assign sts.div_last  = (div_cnt_q == DIVC_W'(SEED_W - 1));
	assign sts.in_range  = (pos_ext < act_ext);

	// response contents
	always_comb begin
		res = '0;
		case (cmd.res_kind)
			RES_DATA: res.entry_value  = rd_q;
			RES_OOR:  res.out_of_range = 1'b1;
			default:  res = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/sis_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ctrl
// Controller: sequences the table fill, the per-entry generator, remainder
// and swap steps of a shuffle pass, table reads and the response handoff.
// ----------------------------------------------------------------------------
module sis_ctrl import sis_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [OP_W-1:0] req_op,
	output logic            req_stall,
	input  sis_sts_t        sts,
	input  logic            rsp_free,
	output logic            rsp_load,
	output sis_cmd_t        cmd
);

	typedef enum logic [19:0] {
		S_CLEAR    = 20'h00001,
		S_IDLE     = 20'h00002,
		S_FILL     = 20'h00004,
		S_SH_CHECK = 20'h00008,
		S_RNG      = 20'h00010,
		S_M1_LO    = 20'h00020,
		S_M1_HX    = 20'h00040,
		S_M1_HK    = 20'h00080,
		S_MIX      = 20'h00100,
		S_M2_LO    = 20'h00200,
		S_M2_HX    = 20'h00400,
		S_M2_HK    = 20'h00800,
		S_DLOAD    = 20'h01000,
		S_DIV      = 20'h02000,
		S_SW_RA    = 20'h04000,
		S_SW_RB    = 20'h08000,
		S_SW_WA    = 20'h10000,
		S_SW_WB    = 20'h20000,
		S_RD_ISSUE = 20'h40000,
		S_RESULT   = 20'h80000
	} state_t;

	state_t    state_q;
	state_t    state_d;
	res_kind_t res_kind_q;
	res_kind_t res_kind_d;

	assign req_stall = (state_q != S_IDLE);

	// state and response kind registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			res_kind_q <= RES_ZERO;
		end else begin
			state_q    <= state_d;
			res_kind_q <= res_kind_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		res_kind_d   = res_kind_q;
		rsp_load     = 1'b0;
		cmd          = '0;
		cmd.res_kind = res_kind_q;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_sel = WR_FILL;
				if (sts.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.take   = 1'b1;
					res_kind_d = RES_ZERO;
					case (req_op)
						OP_INIT: begin
							cmd.rng_load   = 1'b1;
							cmd.fill_start = 1'b1;
							state_d        = S_FILL;
						end
						OP_SHUFFLE: begin
							cmd.i_load = 1'b1;
							state_d    = S_SH_CHECK;
						end
						OP_READ: begin
							state_d = S_RD_ISSUE;
						end
						default: begin
							state_d = S_RESULT;
						end
					endcase
				end
			end
			S_FILL: begin
				cmd.wr_sel = WR_FILL;
				if (sts.fill_last) begin
					state_d = S_RESULT;
				end
			end
			S_SH_CHECK: begin
				state_d = sts.i_gt1 ? S_RNG : S_RESULT;
			end
			S_RNG: begin
				cmd.rng_adv = 1'b1;
				state_d     = S_M1_LO;
			end
			S_M1_LO: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_phase = MUL_LO;
				state_d       = S_M1_HX;
			end
			S_M1_HX: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_phase = MUL_HI_X;
				state_d       = S_M1_HK;
			end
			S_M1_HK: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_phase = MUL_HI_K;
				state_d       = S_MIX;
			end
			S_MIX: begin
				cmd.mix27 = 1'b1;
				state_d   = S_M2_LO;
			end
			S_M2_LO: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				cmd.mul_phase = MUL_LO;
				state_d       = S_M2_HX;
			end
			S_M2_HX: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				cmd.mul_phase = MUL_HI_X;
				state_d       = S_M2_HK;
			end
			S_M2_HK: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				cmd.mul_phase = MUL_HI_K;
				state_d       = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SW_RA;
				end
			end
			S_SW_RA: begin
				cmd.rd_sel = RD_A;
				state_d    = S_SW_RB;
			end
			S_SW_RB: begin
				cmd.rd_sel = RD_J;
				cmd.tmp_ld = 1'b1;
				state_d    = S_SW_WA;
			end
			S_SW_WA: begin
				cmd.wr_sel = WR_A;
				state_d    = S_SW_WB;
			end
			S_SW_WB: begin
				cmd.wr_sel = WR_B;
				cmd.i_dec  = 1'b1;
				state_d    = S_SH_CHECK;
			end
			S_RD_ISSUE: begin
				if (sts.in_range) begin
					cmd.rd_sel = RD_POS;
					res_kind_d = RES_DATA;
				end else begin
					res_kind_d = RES_OOR;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/seeded_index_shuffler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeded_index_shuffler
// Seeded Fisher-Yates shuffle of an index table driven by a splitmix64
// generator; init, shuffle pass and read items, one response per item.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  sis_req_t   (op, position)
//   rsp      out  rsp_valid / rsp_stall  sis_rsp_t   (entry_value, out_of_range)
//   cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// One item at a time. A shuffle over n active entries runs, for each of
// the entries from n down to 2, the generator through the shared 32x32
// multiplier, then the bit-serial remainder and the table swap.
// After reset a clearing pass loads the identity order before the first
// item is taken. The response sits in an output register, so the next
// item is taken while an earlier response is stalled.
// ----------------------------------------------------------------------------
module seeded_index_shuffler import sis_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  sis_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output sis_rsp_t             rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_wdata
);

	logic [COUNT_W-1:0] count_q;
	logic [SEED_W-1:0]  seed_q;
	logic               rsp_valid_q;
	sis_rsp_t           rsp_q;
	sis_rsp_t           res;
	logic               rsp_free;
	logic               rsp_load;
	sis_cmd_t           cmd;
	sis_sts_t           sts;

	// configuration registers and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= RESET_COUNT;
			seed_q      <= RESET_SEED;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_COUNT: count_q <= cfg_wdata[COUNT_W-1:0];
					CFG_SEED_VALUE:  seed_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// controller
	sis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.sts       (sts),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.cmd       (cmd)
	);

	// datapath
	sis_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.position    (req.position),
		.entry_count (count_q),
		.seed_value  (seed_q),
		.res         (res)
	);

	// an accepted item makes the block busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item taken while block stayed ready");

	// a response is only loaded into a free output register
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("response register overwritten");

	// an out-of-range flag never comes with an entry value
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> (rsp.entry_value == '0))
		else $error("out-of-range response carries data");

	// a response is loaded only while an item is in progress
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> req_stall)
		else $error("response loaded while idle");

endmodule
`default_nettype wire
